@@ hdl/mexp_pkg.sv @@
`default_nettype none

package mexp_pkg;

    localparam int MEXP_WORD_BITS = 32;

    // Configuration register indexes
    localparam logic CFG_EXPONENT = 1'b0;
    localparam logic CFG_MODULUS  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_STEP   = 5'b00100,
        S_WAIT   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

endpackage

`default_nettype wire

@@ hdl/mexp_modmul.sv @@
`default_nettype none

module mexp_modmul
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = MEXP_WORD_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [WORD_BITS-1:0] i_a,
    input  wire logic [WORD_BITS-1:0] i_b,
    input  wire logic [WORD_BITS-1:0] i_m,
    output logic                      o_done,
    output logic [WORD_BITS-1:0]      o_res
);

    localparam int CNT_W = $clog2(WORD_BITS + 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [WORD_BITS-1:0] r_r, n_r;
    logic [WORD_BITS-1:0] r_a, n_a;
    logic [WORD_BITS-1:0] r_b, n_b;

    logic [WORD_BITS+1:0] s_sum;
    logic [WORD_BITS+2:0] s_d1;
    logic [WORD_BITS+2:0] s_d2;
    logic [WORD_BITS-1:0] s_next;

    // One multiplier bit per cycle, MSB first: r = 2r + bit*a, then fold below m.
    // With r < m and a < m the sum stays below 3m, so at most 2m comes off.
    always_comb begin
        s_sum = {1'b0, r_r, 1'b0} + {2'b00, (r_b[WORD_BITS-1] ? r_a : '0)};
        s_d1  = {1'b0, s_sum} - {3'b000, i_m};
        s_d2  = {1'b0, s_sum} - {2'b00, i_m, 1'b0};
        if (!s_d2[WORD_BITS+2]) begin
            s_next = s_d2[WORD_BITS-1:0];
        end else if (!s_d1[WORD_BITS+2]) begin
            s_next = s_d1[WORD_BITS-1:0];
        end else begin
            s_next = s_sum[WORD_BITS-1:0];
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_r    = r_r;
        n_a    = r_a;
        n_b    = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(WORD_BITS);
            n_r    = '0;
            n_a    = i_a;
            n_b    = i_b;
        end else if (r_busy) begin
            n_r   = s_next;
            n_b   = {r_b[WORD_BITS-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_r   <= n_r;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_done = r_done;
    assign o_res  = r_r;

endmodule

`default_nettype wire

@@ hdl/modular_exponentiation_top.sv @@
// Modular exponentiation, right-to-left square and multiply: each transfer on
// the input channel yields one result, message_block ^ exponent mod modulus.
// Write exponent (index 0) and modulus (index 1) only while no item is in
// flight; both reset to 1. One item is processed at a time. The input is first
// reduced modulo the modulus, then each exponent bit up to the highest set one
// takes a square and, where the bit is set, a multiply, running side by side
// in two bit-serial modular multipliers, and the result then passes through
// the done state into the output register. A zero exponent yields 1 and a
// zero modulus yields 0, the latter skipping straight to the done state.
`default_nettype none

module modular_exponentiation_top
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = MEXP_WORD_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_index,
    input  wire logic [WORD_BITS-1:0] i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [WORD_BITS-1:0] i_message_block,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [WORD_BITS-1:0]      o_result_block
);

    t_state               r_state, n_state;
    logic [WORD_BITS-1:0] r_exponent, n_exponent;
    logic [WORD_BITS-1:0] r_modulus, n_modulus;
    logic [WORD_BITS-1:0] r_base, n_base;
    logic [WORD_BITS-1:0] r_acc, n_acc;
    logic [WORD_BITS-1:0] r_exp, n_exp;
    logic                 r_mul, n_mul;
    logic                 r_out_valid, n_out_valid;
    logic [WORD_BITS-1:0] r_out_data, n_out_data;

    logic                 s_sq_start;
    logic [WORD_BITS-1:0] s_sq_a;
    logic [WORD_BITS-1:0] s_sq_b;
    logic                 s_sq_done;
    logic [WORD_BITS-1:0] s_sq_res;
    logic                 s_ml_start;
    logic                 s_ml_done;
    logic [WORD_BITS-1:0] s_ml_res;
    logic                 s_in_xfer;
    logic                 s_out_xfer;

    assign s_in_xfer  = i_in_valid && !o_in_stall;
    assign s_out_xfer = r_out_valid && !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_exponent  = r_exponent;
        n_modulus   = r_modulus;
        n_base      = r_base;
        n_acc       = r_acc;
        n_exp       = r_exp;
        n_mul       = r_mul;
        n_out_valid = r_out_valid && !s_out_xfer;
        n_out_data  = r_out_data;
        s_sq_start  = 1'b0;
        s_sq_a      = r_base;
        s_sq_b      = r_base;
        s_ml_start  = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPONENT: n_exponent = i_cfg_data;
                CFG_MODULUS:  n_modulus  = i_cfg_data;
                default:      n_exponent = r_exponent;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (s_in_xfer) begin
                    n_exp = r_exponent;
                    if (r_modulus == '0) begin
                        n_acc   = '0;
                        n_state = S_DONE;
                    end else begin
                        // block * (1 mod m) gives block mod m
                        n_acc      = WORD_BITS'(1);
                        s_sq_start = 1'b1;
                        s_sq_a     = WORD_BITS'(r_modulus != WORD_BITS'(1));
                        s_sq_b     = i_message_block;
                        n_state    = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (s_sq_done) begin
                    n_base  = s_sq_res;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_exp == '0) begin
                    n_state = S_DONE;
                end else begin
                    s_sq_start = 1'b1;
                    s_ml_start = r_exp[0];
                    n_mul      = r_exp[0];
                    n_state    = S_WAIT;
                end
            end
            S_WAIT: begin
                if (s_sq_done && (s_ml_done || !r_mul)) begin
                    n_base = s_sq_res;
                    if (r_mul) begin
                        n_acc = s_ml_res;
                    end
                    n_exp   = {1'b0, r_exp[WORD_BITS-1:1]};
                    n_state = S_STEP;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exponent  <= WORD_BITS'(1);
            r_modulus   <= WORD_BITS'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exponent  <= n_exponent;
            r_modulus   <= n_modulus;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base     <= n_base;
        r_acc      <= n_acc;
        r_exp      <= n_exp;
        r_mul      <= n_mul;
        r_out_data <= n_out_data;
    end

    // Squares the base (and reduces the input block at the start)
    mexp_modmul #(
        .WORD_BITS (WORD_BITS)
    ) u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_sq_start),
        .i_a     (s_sq_a),
        .i_b     (s_sq_b),
        .i_m     (r_modulus),
        .o_done  (s_sq_done),
        .o_res   (s_sq_res)
    );

    // Multiplies the running result by the base; scans the result's bits
    mexp_modmul #(
        .WORD_BITS (WORD_BITS)
    ) u_ml (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_ml_start),
        .i_a     (r_base),
        .i_b     (r_acc),
        .i_m     (r_modulus),
        .o_done  (s_ml_done),
        .o_res   (s_ml_res)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_block = r_out_data;

endmodule

`default_nettype wire

@@ hdl/mexp_checker.sv @@
`default_nettype none

module mexp_checker
    import mexp_pkg::*;
#(
    parameter int WORD_BITS = MEXP_WORD_BITS
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [WORD_BITS-1:0] o_result_block
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_block))
        else $error("stalled result changed");

    // One item at a time: an input transfer closes the input side
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open straight after a transfer");

    // No result appears in the cycle right after an input transfer
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result too early");

    // Delivering a result reopens the input side
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("input still closed when result appears");

endmodule

bind modular_exponentiation_top mexp_checker #(
    .WORD_BITS (WORD_BITS)
) u_mexp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_block (o_result_block)
);

`default_nettype wire
